### rtl/core/rc5d_pkg.sv
// ----------------------------------------------------------------------------
// rc5d_pkg
// Types, codes and constants shared by the RC5 infrared frame decoder.
// ----------------------------------------------------------------------------
package rc5d_pkg;

	localparam int FRAME_BITS = 14;
	localparam int CNT_W      = $clog2(FRAME_BITS + 1);

	localparam int TICK_W     = 7;   // tick period register
	localparam int TIME_W     = 12;  // nominal and tolerance registers
	localparam int TICKS_W    = 8;   // interval ticks field
	localparam int T_W        = TICKS_W + TICK_W;  // interval in microseconds
	localparam int CMP_W      = T_W + 1;

	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = TIME_W;

	localparam logic [TICK_W-1:0] TICK_PERIOD_RST = TICK_W'(16);
	localparam logic [TIME_W-1:0] SHORT_TIME_RST  = TIME_W'(889);
	localparam logic [TIME_W-1:0] LONG_TIME_RST   = TIME_W'(1778);
	localparam logic [TIME_W-1:0] TOLERANCE_RST   = TIME_W'(444);

	typedef enum logic [1:0] {
		REQ_EDGE    = 2'd0,
		REQ_TIMEOUT = 2'd1,
		REQ_TAKE    = 2'd2
	} req_type_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_TICK_PERIOD = 2'd0,
		CFG_SHORT_TIME  = 2'd1,
		CFG_LONG_TIME   = 2'd2,
		CFG_TOLERANCE   = 2'd3
	} cfg_idx_t;

	typedef enum logic [2:0] {
		ST_START1 = 3'd0,
		ST_MID1   = 3'd1,
		ST_START0 = 3'd2,
		ST_MID0   = 3'd3,
		ST_RESET  = 3'd4
	} dec_phase_t;

	typedef struct packed {
		logic [TICK_W-1:0] tick_period_us;
		logic [TIME_W-1:0] short_time_us;
		logic [TIME_W-1:0] long_time_us;
		logic [TIME_W-1:0] tolerance_us;
	} cfg_t;

	typedef struct packed {
		dec_phase_t            st;
		logic [FRAME_BITS-1:0] frame;
		logic [CNT_W-1:0]      cnt;
	} dec_state_t;

	localparam dec_state_t DEC_CLEAR = '{st: ST_RESET, frame: '0, cnt: '0};

endpackage

### rtl/core/rc5d_req_if.sv
// ----------------------------------------------------------------------------
// rc5d_req_if
// Request channel: edge events, timeouts and take requests.
// ----------------------------------------------------------------------------
interface rc5d_req_if;
	logic                      valid;
	logic                      ready;
	logic [1:0]                req_type;
	logic                      pin_level;
	logic [rc5d_pkg::TICKS_W-1:0] interval_ticks;

	modport source (output valid, output req_type, output pin_level,
		output interval_ticks, input ready);
	modport sink (input valid, input req_type, input pin_level,
		input interval_ticks, output ready);
endinterface

### rtl/core/rc5d_rsp_if.sv
// ----------------------------------------------------------------------------
// rc5d_rsp_if
// Response channel: one result per request.
// ----------------------------------------------------------------------------
interface rc5d_rsp_if;
	logic                            valid;
	logic                            ready;
	logic                            msg_valid;
	logic [rc5d_pkg::FRAME_BITS-1:0] frame;
	logic [rc5d_pkg::CNT_W-1:0]      bits_held;

	modport source (output valid, output msg_valid, output frame,
		output bits_held, input ready);
	modport sink (input valid, input msg_valid, input frame,
		input bits_held, output ready);
endinterface

### rtl/core/rc5d_step.sv
// ----------------------------------------------------------------------------
// rc5d_step
// Manchester decode step: classes the interval and advances the machine.
// ----------------------------------------------------------------------------
module rc5d_step (
	input  rc5d_pkg::cfg_t                  cfg,
	input  rc5d_pkg::dec_state_t            cur,
	input  logic [1:0]                      req_type,
	input  logic                            pin_level,
	input  logic [rc5d_pkg::T_W-1:0]        t_us,
	output rc5d_pkg::dec_state_t            nxt,
	output logic                            msg_valid,
	output logic [rc5d_pkg::FRAME_BITS-1:0] frame
);
	import rc5d_pkg::*;

	logic             space;
	logic             is_short;
	logic             is_long;
	logic             full;
	logic             rec;
	logic             rec_bit;
	dec_phase_t       st_edge;
	dec_state_t       after_edge;
	logic [CMP_W-1:0] t_ext;
	logic [CMP_W-1:0] tol_ext;

	assign space   = !pin_level;
	assign full    = (cur.cnt == CNT_W'(FRAME_BITS));
	assign t_ext   = CMP_W'(t_us);
	assign tol_ext = CMP_W'(cfg.tolerance_us);

	// lower bound checked as t + tol >= nominal so it never goes negative
	assign is_short = (t_ext + tol_ext >= CMP_W'(cfg.short_time_us)) &&
		(t_ext <= CMP_W'(cfg.short_time_us) + tol_ext);
	assign is_long  = (t_ext + tol_ext >= CMP_W'(cfg.long_time_us)) &&
		(t_ext <= CMP_W'(cfg.long_time_us) + tol_ext);

	always_comb begin
		st_edge = cur.st;
		rec     = 1'b0;
		rec_bit = 1'b0;
		unique case (cur.st)
			ST_RESET: begin
				st_edge = ST_MID1;
				rec     = 1'b1;
				rec_bit = 1'b1;
			end
			ST_START1: begin
				if (space && is_short) begin
					st_edge = ST_MID1;
					rec     = 1'b1;
					rec_bit = 1'b1;
				end
			end
			ST_MID1: begin
				if (!space && is_short) begin
					st_edge = ST_START1;
				end else if (!space && is_long) begin
					st_edge = ST_MID0;
					rec     = 1'b1;
				end
			end
			ST_MID0: begin
				if (space && is_long) begin
					st_edge = ST_MID1;
					rec     = 1'b1;
					rec_bit = 1'b1;
				end else if (space && is_short) begin
					st_edge = ST_START0;
				end
			end
			ST_START0: begin
				if (!space && is_short) begin
					st_edge = ST_MID0;
					rec     = 1'b1;
				end
			end
			default: st_edge = ST_RESET;
		endcase
	end

	always_comb begin
		after_edge    = cur;
		after_edge.st = st_edge;
		if (cur.st != ST_START1 && cur.st != ST_MID1 && cur.st != ST_START0 &&
			cur.st != ST_MID0 && cur.st != ST_RESET) begin
			after_edge = DEC_CLEAR;
		end else if (rec) begin
			// shifting left leaves the first bit at the top once the frame is full
			after_edge.frame = {cur.frame[FRAME_BITS-2:0], rec_bit};
			after_edge.cnt   = cur.cnt + CNT_W'(1);
		end
		// start check: the first two bits must both be 1
		if (after_edge.cnt == CNT_W'(2) && after_edge.frame[1:0] != 2'b11) begin
			after_edge = DEC_CLEAR;
		end
	end

	// next state
	always_comb begin
		nxt = cur;
		case (req_type)
			REQ_EDGE:    if (!full) nxt = after_edge;
			REQ_TIMEOUT: if (!full) nxt = DEC_CLEAR;
			REQ_TAKE:    if (full) nxt = DEC_CLEAR;
			default:     nxt = cur;
		endcase
	end

	// result
	always_comb begin
		msg_valid = (req_type == REQ_TAKE) && full;
		frame     = msg_valid ? cur.frame : '0;
	end

endmodule

### rtl/core/rc5_ir_frame_decoder_core.sv
// ----------------------------------------------------------------------------
// rc5_ir_frame_decoder_core
// RC5 frame decoder driven by edge, timeout and take requests.
// ----------------------------------------------------------------------------
// stages: input register then result register; a result is registered once
//   its request has passed the input register and rsp is not stalled
// throughput: one request per cycle unless rsp stalls; the interval multiply
//   feeds the input register; the decode step feeds the result register
// reset: arst_n clears the decoder to await the first edge and loads the
//   default timing registers
module rc5_ir_frame_decoder_core (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [rc5d_pkg::CFG_IDX_W-1:0] cfg_idx,
	input  logic [rc5d_pkg::CFG_DATA_W-1:0] cfg_wdata,
	rc5d_req_if.sink                       req,
	rc5d_rsp_if.source                     rsp
);
	import rc5d_pkg::*;

	cfg_t                  cfg_q;
	dec_state_t            dec_q;
	dec_state_t            dec_nxt;

	logic                  valid_s1;
	logic [1:0]            req_type_s1;
	logic                  pin_level_s1;
	logic [T_W-1:0]        t_us_s1;

	logic                  rsp_valid_q;
	logic                  msg_valid_q;
	logic [FRAME_BITS-1:0] frame_q;
	logic [CNT_W-1:0]      bits_held_q;

	logic                  step_msg_valid;
	logic [FRAME_BITS-1:0] step_frame;
	logic                  advance;

	assign advance   = !rsp_valid_q || rsp.ready;
	assign req.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.tick_period_us <= TICK_PERIOD_RST;
			cfg_q.short_time_us  <= SHORT_TIME_RST;
			cfg_q.long_time_us   <= LONG_TIME_RST;
			cfg_q.tolerance_us   <= TOLERANCE_RST;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				CFG_TICK_PERIOD: cfg_q.tick_period_us <= cfg_wdata[TICK_W-1:0];
				CFG_SHORT_TIME:  cfg_q.short_time_us  <= cfg_wdata[TIME_W-1:0];
				CFG_LONG_TIME:   cfg_q.long_time_us   <= cfg_wdata[TIME_W-1:0];
				CFG_TOLERANCE:   cfg_q.tolerance_us   <= cfg_wdata[TIME_W-1:0];
				default: ;
			endcase
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req.ready) begin
			valid_s1 <= req.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			req_type_s1  <= req.req_type;
			pin_level_s1 <= req.pin_level;
			t_us_s1      <= T_W'(req.interval_ticks) * T_W'(cfg_q.tick_period_us);
		end
	end

	rc5d_step u_step (
		.cfg       (cfg_q),
		.cur       (dec_q),
		.req_type  (req_type_s1),
		.pin_level (pin_level_s1),
		.t_us      (t_us_s1),
		.nxt       (dec_nxt),
		.msg_valid (step_msg_valid),
		.frame     (step_frame)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dec_q       <= DEC_CLEAR;
			rsp_valid_q <= 1'b0;
		end else if (advance) begin
			rsp_valid_q <= valid_s1;
			if (valid_s1) begin
				dec_q <= dec_nxt;
			end
		end
	end

	// result register
	always_ff @(posedge clk) begin
		if (advance && valid_s1) begin
			msg_valid_q <= step_msg_valid;
			frame_q     <= step_frame;
			bits_held_q <= dec_nxt.cnt;
		end
	end

	assign rsp.valid     = rsp_valid_q;
	assign rsp.msg_valid = msg_valid_q;
	assign rsp.frame     = frame_q;
	assign rsp.bits_held = bits_held_q;

endmodule

### rtl/core/rc5d_checker.sv
// ----------------------------------------------------------------------------
// rc5d_checker
// Port-level checks for the RC5 frame decoder, bound to the top level.
// ----------------------------------------------------------------------------
module rc5d_checker (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            req_ready,
	input logic                            rsp_valid,
	input logic                            rsp_ready,
	input logic                            msg_valid,
	input logic [rc5d_pkg::FRAME_BITS-1:0] frame,
	input logic [rc5d_pkg::CNT_W-1:0]      bits_held
);
	import rc5d_pkg::*;

	// a returned frame leaves the decoder empty
	a_take_clears: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && msg_valid |-> bits_held == '0)
		else $error("frame returned but bits still held");

	a_frame_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !msg_valid |-> frame == '0)
		else $error("frame nonzero without msg_valid");

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> bits_held <= CNT_W'(FRAME_BITS))
		else $error("bits_held beyond frame length");

	// an empty result register never blocks the request side
	a_no_idle_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!rsp_valid |-> req_ready)
		else $error("request stalled with empty result register");

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(msg_valid) &&
			$stable(frame) && $stable(bits_held))
		else $error("stalled result changed");

endmodule

bind rc5_ir_frame_decoder_core rc5d_checker u_rc5d_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.req_ready (req.ready),
	.rsp_valid (rsp.valid),
	.rsp_ready (rsp.ready),
	.msg_valid (rsp.msg_valid),
	.frame     (rsp.frame),
	.bits_held (rsp.bits_held)
);

### bench/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the RC5 infrared frame decoder. Well-formed
// Manchester frames with random content, broken and truncated frames, and
// random noise requests go through the decoder under several timing settings.
// The expected answers come from a cycle-free decoder model and are checked
// field by field, in order.
// ----------------------------------------------------------------------------
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import rc5d_pkg::*;

	localparam logic [1:0] REQ_UNUSED  = 2'd3;   // request code that does nothing
	localparam int         LIMIT_CYCLES = 400000;

	typedef struct {
		logic [1:0]         rtype;
		logic               pin;
		logic [TICKS_W-1:0] ticks;
	} rc5_req_item_t;

	typedef struct {
		logic                  msg_valid;
		logic [FRAME_BITS-1:0] frame;
		logic [CNT_W-1:0]      bits_held;
	} rc5_answer_t;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [CFG_IDX_W-1:0] cfg_idx;
	logic [CFG_DATA_W-1:0] cfg_wdata;

	rc5d_req_if req_ch ();
	rc5d_rsp_if rsp_ch ();

	rc5_ir_frame_decoder_core i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_idx   (cfg_idx),
		.cfg_wdata (cfg_wdata),
		.req       (req_ch),
		.rsp       (rsp_ch)
	);

	// decoder model state and its copy of the timing registers
	cfg_t                  model_cfg;
	dec_phase_t            model_st;
	logic [FRAME_BITS-1:0] model_frame;
	int                    model_cnt;

	rc5_req_item_t pending_items[$];
	rc5_answer_t   decoder_answers_due[$];
	rc5_req_item_t cur_item;
	rc5_answer_t   want;

	int  n_queued = 0;
	int  n_accepted = 0;
	int  n_errors = 0;
	int  n_frames_out = 0;
	int  n_settings = 1;
	int  cycle_cnt = 0;
	logic req_taken = 1'b0;
	wire calm = (cycle_cnt % 3000) >= 2400;

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	function automatic bit in_window(int t, logic [TIME_W-1:0] nominal);
		int lo;
		int hi;
		lo = int'(nominal) - int'(model_cfg.tolerance_us);
		hi = int'(nominal) + int'(model_cfg.tolerance_us);
		return t >= lo && t <= hi;
	endfunction

	function automatic void clear_model();
		model_st = ST_RESET;
		model_frame = '0;
		model_cnt = 0;
	endfunction

	function automatic void shift_in(logic b);
		if (model_cnt < FRAME_BITS) begin
			model_frame[FRAME_BITS-1-model_cnt] = b;
			model_cnt++;
		end
	endfunction

	function automatic void decode_edge(logic pin, logic [TICKS_W-1:0] ticks);
		int t;
		bit space;
		bit is_short;
		bit is_long;
		t = int'(ticks) * int'(model_cfg.tick_period_us);
		space = (pin == 1'b0);
		is_short = in_window(t, model_cfg.short_time_us);
		is_long = in_window(t, model_cfg.long_time_us);
		if (model_cnt == FRAME_BITS)
			return;
		case (model_st)
			ST_RESET: begin
				model_st = ST_MID1;
				shift_in(1'b1);
			end
			ST_START1: begin
				if (space && is_short) begin
					model_st = ST_MID1;
					shift_in(1'b1);
				end
			end
			ST_MID1: begin
				if (!space && is_short) begin
					model_st = ST_START1;
				end else if (!space && is_long) begin
					model_st = ST_MID0;
					shift_in(1'b0);
				end
			end
			ST_MID0: begin
				if (space && is_long) begin
					model_st = ST_MID1;
					shift_in(1'b1);
				end else if (space && is_short) begin
					model_st = ST_START0;
				end
			end
			ST_START0: begin
				if (!space && is_short) begin
					model_st = ST_MID0;
					shift_in(1'b0);
				end
			end
			default: clear_model();
		endcase
		// start check: the two start bits must both be 1
		if (model_cnt == 2 && model_frame[FRAME_BITS-1 -: 2] != 2'b11)
			clear_model();
	endfunction

	function automatic rc5_answer_t predict_decoder_answer(rc5_req_item_t it);
		rc5_answer_t a;
		a.msg_valid = 1'b0;
		a.frame = '0;
		case (it.rtype)
			REQ_EDGE: decode_edge(it.pin, it.ticks);
			REQ_TIMEOUT: begin
				if (model_cnt != FRAME_BITS)
					clear_model();
			end
			REQ_TAKE: begin
				if (model_cnt == FRAME_BITS) begin
					a.msg_valid = 1'b1;
					a.frame = model_frame;
					clear_model();
				end
			end
			default: ;
		endcase
		a.bits_held = CNT_W'(model_cnt);
		return a;
	endfunction

	// request driver
	always @(negedge clk) begin
		if (!arst_n) begin
			req_ch.valid <= 1'b0;
		end else if (!req_ch.valid || req_taken) begin
			if (pending_items.size() != 0 && (calm || $urandom_range(99) >= 31)) begin
				cur_item = pending_items.pop_front();
				req_ch.valid <= 1'b1;
				req_ch.req_type <= cur_item.rtype;
				req_ch.pin_level <= cur_item.pin;
				req_ch.interval_ticks <= cur_item.ticks;
			end else begin
				req_ch.valid <= 1'b0;
			end
		end
		rsp_ch.ready <= arst_n && (calm || $urandom_range(99) >= 31);
	end

	// request and answer monitor
	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt == LIMIT_CYCLES) begin
			$display("%0t: run timed out, %0d answers outstanding", $time,
				decoder_answers_due.size());
			$display("testbench: done, errors");
			$finish;
		end
		req_taken <= arst_n && req_ch.valid && req_ch.ready;
		if (arst_n && req_ch.valid && req_ch.ready) begin
			cur_item.rtype = req_ch.req_type;
			cur_item.pin = req_ch.pin_level;
			cur_item.ticks = req_ch.interval_ticks;
			decoder_answers_due.push_back(predict_decoder_answer(cur_item));
			n_accepted <= n_accepted + 1;
		end
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			if (decoder_answers_due.size() == 0) begin
				n_errors++;
				$display("%0t: answer with none expected: msg_valid %0b frame %h bits %0d",
					$time, rsp_ch.msg_valid, rsp_ch.frame, rsp_ch.bits_held);
			end else begin
				want = decoder_answers_due.pop_front();
				if (rsp_ch.msg_valid !== want.msg_valid) begin
					n_errors++;
					$display("%0t: msg_valid expected %0b actual %0b", $time,
						want.msg_valid, rsp_ch.msg_valid);
				end
				if (rsp_ch.frame !== want.frame) begin
					n_errors++;
					$display("%0t: frame expected %h actual %h", $time,
						want.frame, rsp_ch.frame);
				end
				if (rsp_ch.bits_held !== want.bits_held) begin
					n_errors++;
					$display("%0t: bits_held expected %0d actual %0d", $time,
						want.bits_held, rsp_ch.bits_held);
				end
				if (want.msg_valid)
					n_frames_out++;
			end
		end
	end

	task automatic push_req(logic [1:0] rtype, logic pin, logic [TICKS_W-1:0] ticks);
		rc5_req_item_t it;
		it.rtype = rtype;
		it.pin = pin;
		it.ticks = ticks;
		pending_items.push_back(it);
		n_queued++;
	endtask

	// tick count inside the window around a nominal time, if one exists
	function automatic logic [TICKS_W-1:0] pick_ticks(logic [TIME_W-1:0] nominal);
		int tp;
		int lo;
		int hi;
		int tlo;
		int thi;
		tp = int'(model_cfg.tick_period_us);
		lo = int'(nominal) - int'(model_cfg.tolerance_us);
		hi = int'(nominal) + int'(model_cfg.tolerance_us);
		if (lo < 0)
			lo = 0;
		if (tp == 0)
			return TICKS_W'($urandom_range(255));
		tlo = (lo + tp - 1) / tp;
		thi = hi / tp;
		if (thi > 255)
			thi = 255;
		if (tlo > thi)
			return TICKS_W'($urandom_range(255));
		return TICKS_W'($urandom_range(thi, tlo));
	endfunction

	// manchester edges for a frame; the first bit is the start edge
	task automatic push_frame(logic [FRAME_BITS-1:0] bits, int nbits, int glitch_pct);
		int i;
		logic last;
		logic b;
		push_req(REQ_EDGE, 1'($urandom_range(1)), TICKS_W'($urandom_range(255)));
		last = 1'b1;
		for (i = 1; i < nbits; i++) begin
			b = bits[FRAME_BITS-1-i];
			if ($urandom_range(99) < glitch_pct)
				push_req(REQ_EDGE, 1'($urandom_range(1)), TICKS_W'($urandom_range(255)));
			if (last) begin
				if (b) begin
					push_req(REQ_EDGE, 1'b1, pick_ticks(model_cfg.short_time_us));
					push_req(REQ_EDGE, 1'b0, pick_ticks(model_cfg.short_time_us));
				end else begin
					push_req(REQ_EDGE, 1'b1, pick_ticks(model_cfg.long_time_us));
				end
			end else begin
				if (b) begin
					push_req(REQ_EDGE, 1'b0, pick_ticks(model_cfg.long_time_us));
				end else begin
					push_req(REQ_EDGE, 1'b0, pick_ticks(model_cfg.short_time_us));
					push_req(REQ_EDGE, 1'b1, pick_ticks(model_cfg.short_time_us));
				end
			end
			last = b;
		end
	endtask

	task automatic push_random_traffic(int n);
		int start;
		int r;
		int k;
		start = n_queued;
		while (n_queued - start < n) begin
			r = $urandom_range(99);
			if (r < 65) begin
				push_frame({2'b11, 12'($urandom)}, FRAME_BITS, 3);
				if ($urandom_range(99) < 20)
					push_req(REQ_EDGE, 1'($urandom_range(1)), TICKS_W'($urandom_range(255)));
			end else if (r < 75) begin
				push_frame({1'b1, 13'($urandom)}, FRAME_BITS, 0);
			end else if (r < 87) begin
				push_frame({2'b11, 12'($urandom)}, $urandom_range(FRAME_BITS - 1, 1), 0);
			end else begin
				for (k = $urandom_range(4, 1); k > 0; k--)
					push_req(2'($urandom_range(3)), 1'($urandom_range(1)),
						TICKS_W'($urandom_range(255)));
			end
			// back to the idle state either way
			if ($urandom_range(1)) begin
				push_req(REQ_TAKE, 1'($urandom_range(1)), TICKS_W'($urandom_range(255)));
				push_req(REQ_TIMEOUT, 1'($urandom_range(1)), TICKS_W'($urandom_range(255)));
			end else begin
				push_req(REQ_TIMEOUT, 1'($urandom_range(1)), TICKS_W'($urandom_range(255)));
				push_req(REQ_TAKE, 1'($urandom_range(1)), TICKS_W'($urandom_range(255)));
			end
		end
	endtask

	task automatic wait_drained();
		do
			@(negedge clk);
		while (n_accepted != n_queued || decoder_answers_due.size() != 0);
		repeat (4) @(negedge clk);
	endtask

	// called at a falling edge, returns at a falling edge
	task automatic set_register(cfg_idx_t idx, int value);
		cfg_we <= 1'b1;
		cfg_idx <= idx;
		cfg_wdata <= CFG_DATA_W'(value);
		case (idx)
			CFG_TICK_PERIOD: model_cfg.tick_period_us = TICK_W'(value);
			CFG_SHORT_TIME:  model_cfg.short_time_us = TIME_W'(value);
			CFG_LONG_TIME:   model_cfg.long_time_us = TIME_W'(value);
			CFG_TOLERANCE:   model_cfg.tolerance_us = TIME_W'(value);
			default: ;
		endcase
		@(negedge clk);
		cfg_we <= 1'b0;
		@(negedge clk);
	endtask

	task automatic run_setting(int tp, int short_us, int long_us, int tol_us, int n);
		wait_drained();
		set_register(CFG_TICK_PERIOD, tp);
		set_register(CFG_SHORT_TIME, short_us);
		set_register(CFG_LONG_TIME, long_us);
		set_register(CFG_TOLERANCE, tol_us);
		n_settings++;
		@(posedge clk);
		push_random_traffic(n);
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_idx = '0;
		cfg_wdata = '0;
		req_ch.valid = 1'b0;
		req_ch.req_type = REQ_EDGE;
		req_ch.pin_level = 1'b0;
		req_ch.interval_ticks = '0;
		rsp_ch.ready = 1'b0;
		model_cfg = '{tick_period_us: TICK_PERIOD_RST, short_time_us: SHORT_TIME_RST,
			long_time_us: LONG_TIME_RST, tolerance_us: TOLERANCE_RST};
		clear_model();
		repeat (5) @(negedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed part at the reset timing
		push_req(REQ_TAKE, 1'b0, 8'd0);          // take with nothing held
		push_req(REQ_TIMEOUT, 1'b1, 8'd255);
		push_req(REQ_UNUSED, 1'b1, 8'd255);
		push_req(REQ_EDGE, 1'b0, 8'd0);          // first edge records the start bit
		push_req(REQ_EDGE, 1'b1, 8'd255);        // fits no window
		push_req(REQ_EDGE, 1'b1, pick_ticks(model_cfg.long_time_us));  // start bits 10
		push_req(REQ_EDGE, 1'b1, 8'd0);
		push_req(REQ_TIMEOUT, 1'b0, 8'd0);       // timeout drops a partial frame
		push_frame(14'b11010101010101, FRAME_BITS, 0);
		push_req(REQ_EDGE, 1'b0, pick_ticks(model_cfg.long_time_us));  // frame full
		push_req(REQ_TIMEOUT, 1'b1, 8'd0);       // complete frame survives
		push_req(REQ_TAKE, 1'b1, 8'd255);

		push_random_traffic(170);
		run_setting(1, 100, 200, 0, 170);
		run_setting(64, 0, 4095, 4095, 170);     // intervals of at most 4095 us fit both windows
		run_setting(1, 0, 0, 0, 150);
		run_setting(7, 889, 1778, 444, 170);
		run_setting(33, 1500, 2500, 700, 170);   // overlapping short and long windows
		run_setting(64, 4095, 2000, 100, 150);
		run_setting(16, 889, 1778, 444, 170);
		wait_drained();
		repeat (8) @(negedge clk);

		if (decoder_answers_due.size() != 0) begin
			n_errors++;
			$display("%0t: %0d answers never arrived", $time, decoder_answers_due.size());
		end
		$display("%0d requests under %0d timing settings, %0d frames returned, %0d errors",
			n_accepted, n_settings, n_frames_out, n_errors);
		if (n_errors == 0)
			$display("testbench: done, clean");
		else
			$display("testbench: done, errors");
		$finish;
	end

endmodule
